>>> rtl/heatmap_cell_store_colormap_assert.svh
// Assertion macros shared by the RTL of the heatmap cell store.
`ifndef HEATMAP_CELL_STORE_COLORMAP_ASSERT_SVH
`define HEATMAP_CELL_STORE_COLORMAP_ASSERT_SVH
`ifndef SYNTHESIS
// The property holds at every clock edge outside reset.
`define HCSC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// The condition never holds outside reset.
`define HCSC_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define HCSC_ASSERT(lbl, clk, rst, prop, msg)
`define HCSC_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

>>> rtl/hcsc_pkg.sv
package hcsc_pkg;

  localparam int unsigned MAX_COLS_DEF = 256;
  localparam int unsigned MAX_ROWS_DEF = 256;

  // Divider operand widths: the largest dividend is 65535 * 255.
  localparam int unsigned DIV_NW = 24;
  localparam int unsigned DIV_DW = 16;
  localparam int unsigned DIV_CW = $clog2(DIV_NW);

  typedef enum logic [2:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_COLS      = 3'd2,
    REG_ROWS      = 3'd3,
    REG_FOCUS_LOW = 3'd4,
    REG_FOCUS_HI  = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_t;

  // One channel of a gradient stop, stops 0 to 4.
  function automatic logic [7:0] stop_level(input logic [2:0] stop, input chan_t ch);
    logic [23:0] rgb;
    begin
      case (stop)
        3'd0:    rgb = {8'd0,   8'd0,   8'd180};
        3'd1:    rgb = {8'd0,   8'd190, 8'd255};
        3'd2:    rgb = {8'd0,   8'd220, 8'd0};
        3'd3:    rgb = {8'd255, 8'd230, 8'd0};
        default: rgb = {8'd255, 8'd0,   8'd0};
      endcase
      case (ch)
        CH_RED:   stop_level = rgb[23:16];
        CH_GREEN: stop_level = rgb[15:8];
        default:  stop_level = rgb[7:0];
      endcase
    end
  endfunction

endpackage

>>> rtl/hcsc_cell_mem.sv
module hcsc_cell_mem #(
  parameter int unsigned AW = 16,
  parameter int unsigned DW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/hcsc_div.sv
// Restoring divider, one quotient bit per cycle.
module hcsc_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [hcsc_pkg::DIV_NW-1:0]  numer,
  input  logic [hcsc_pkg::DIV_DW-1:0]  denom,
  output logic                         done,
  output logic [hcsc_pkg::DIV_NW-1:0]  quot
);

  logic                        busy;
  logic [hcsc_pkg::DIV_CW-1:0] cnt;
  logic [hcsc_pkg::DIV_DW-1:0] rem;
  logic [hcsc_pkg::DIV_DW-1:0] dvs;
  logic [hcsc_pkg::DIV_DW:0]   shifted;
  logic                        qbit;

  assign shifted = {rem, quot[hcsc_pkg::DIV_NW-1]};
  assign qbit    = (shifted >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= hcsc_pkg::DIV_CW'(hcsc_pkg::DIV_NW - 1);
        rem  <= '0;
        quot <= numer;
        dvs  <= denom;
      end else if (busy) begin
        rem  <= qbit ? hcsc_pkg::DIV_DW'(shifted - {1'b0, dvs})
                     : shifted[hcsc_pkg::DIV_DW-1:0];
        quot <= {quot[hcsc_pkg::DIV_NW-2:0], qbit};
        cnt  <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/heatmap_cell_store_colormap.sv
// Heatmap cell store with a five-stop colour map. Each input transaction
// writes a sample into, or reads, one cell of a grid held in a single-port
// synchronous memory of 2**(clog2(MAX_COLS)+clog2(MAX_ROWS)) 16-bit cells
// (65536 with the defaults), and returns one output transaction with the
// cell value, its image position and its RGB colour. After reset the block
// sweeps every cell of the memory to zero, one cell a cycle; s_tready stays
// low during that pass, configuration writes are taken at any time. Items
// are handled one at a time. An out-of-grid item goes straight to the
// output state S_DONE. An in-grid read first passes through the memory-read
// state S_MEM. An in-grid item needs one 24-step division when the value
// lies outside the focus range, none when the focus range is a single
// point, and three inside the focus range, where each of the three channels
// needs its own 24-step division in the shared bit-serial divider; that
// divider sets the rate. A stalled output holds the block in S_DONE until
// m_tready lets the result be loaded. The next item may be accepted while a
// finished result still waits on m_tready.
module heatmap_cell_store_colormap #(
  parameter int unsigned MAX_COLS = hcsc_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS = hcsc_pkg::MAX_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input item stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // coord_x[15:0], coord_y[31:16], sample[47:32]
  input  logic        s_tuser,   // mode: 0 write, 1 read
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // image_col[7:0], image_row[15:8],
                                 // cell_value[31:16], red[39:32],
                                 // green[47:40], blue[55:48]
  output logic        m_tuser,   // hit
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int unsigned XW = $clog2(MAX_COLS);
  localparam int unsigned YW = $clog2(MAX_ROWS);
  localparam int unsigned AW = XW + YW;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_MEM, S_CLASS, S_MUL, S_DIV, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    K_BLUE_GREY, K_RED_GREY, K_GRAD
  } kind_t;

  state_t state;
  kind_t  kind;

  // Configuration registers.
  logic [15:0] origin_x, origin_y, focus_low, focus_high;
  logic [8:0]  cols_in_use, rows_in_use;

  // Per-item registers.
  logic [AW-1:0] clr_addr;
  logic          hit_q;
  logic [7:0]    img_col_q, img_row_q;
  logic [15:0]   val_q;
  logic [1:0]    seg_q;
  logic [16:0]   num_q;
  hcsc_pkg::chan_t chan_q;
  logic [7:0]    red_q, green_q, blue_q;
  logic          div_start;
  logic [hcsc_pkg::DIV_NW-1:0] div_numer, div_quot;
  logic [hcsc_pkg::DIV_DW-1:0] div_denom;
  logic          div_done;

  // Memory port.
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [15:0]   mem_wdata, mem_rdata;

  // Address and bounds check of the offered item.
  logic [16:0] rx, ry, cols_eff, rows_eff, row_img;
  logic        in_hit, in_acc;

  assign rx       = {s_tdata[15], s_tdata[15:0]} - {origin_x[15], origin_x};
  assign ry       = {s_tdata[31], s_tdata[31:16]} - {origin_y[15], origin_y};
  assign cols_eff = (17'(cols_in_use) > 17'(MAX_COLS)) ? 17'(MAX_COLS) : 17'(cols_in_use);
  assign rows_eff = (17'(rows_in_use) > 17'(MAX_ROWS)) ? 17'(MAX_ROWS) : 17'(rows_in_use);
  assign in_hit   = !rx[16] && !ry[16] && (rx < cols_eff) && (ry < rows_eff);
  assign row_img  = rows_eff - 17'd1 - ry;
  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = {rx[XW-1:0], ry[YW-1:0]};
    mem_wdata = s_tdata[47:32];
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_addr  = clr_addr;
      mem_wdata = '0;
    end else if (in_acc && in_hit && !s_tuser) begin
      mem_we = 1'b1;
    end
  end

  hcsc_cell_mem #(.AW(AW), .DW(16)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  hcsc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_numer),
    .denom (div_denom),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Classification of the value against the focus range.
  logic        below, above, flat;
  logic [15:0] span;
  logic [17:0] n4, d1, d2, d3, seg_base;
  logic [1:0]  seg;

  assign below = (val_q < focus_low);
  assign above = (val_q > focus_high);
  assign flat  = (focus_high == focus_low);
  assign span  = focus_high - focus_low;
  assign n4    = {val_q - focus_low, 2'b00};
  assign d1    = 18'(span);
  assign d2    = {d1[16:0], 1'b0};
  assign d3    = d1 + d2;

  always_comb begin
    if (n4 <= d1) begin
      seg = 2'd0;
      seg_base = '0;
    end else if (n4 <= d2) begin
      seg = 2'd1;
      seg_base = d1;
    end else if (n4 <= d3) begin
      seg = 2'd2;
      seg_base = d2;
    end else begin
      seg = 2'd3;
      seg_base = d3;
    end
  end

  // Stop level and slope of the current gradient channel.
  logic [7:0] c_lo, c_hi, dmag, q8;
  logic [8:0] dlt;
  logic       dneg;
  logic [7:0] chan_val;

  assign c_lo     = hcsc_pkg::stop_level({1'b0, seg_q}, chan_q);
  assign c_hi     = hcsc_pkg::stop_level(3'({1'b0, seg_q} + 3'd1), chan_q);
  assign dlt      = {1'b0, c_hi} - {1'b0, c_lo};
  assign dneg     = dlt[8];
  assign dmag     = dneg ? 8'(-dlt) : dlt[7:0];
  assign q8       = div_quot[7:0];
  assign chan_val = dneg ? (c_lo - q8) : (c_lo + q8);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x    <= '0;
      origin_y    <= '0;
      cols_in_use <= 9'd256;
      rows_in_use <= 9'd256;
      focus_low   <= '0;
      focus_high  <= 16'hFFFF;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hcsc_pkg::REG_ORIGIN_X:  origin_x    <= cfg_data;
        hcsc_pkg::REG_ORIGIN_Y:  origin_y    <= cfg_data;
        hcsc_pkg::REG_COLS:      cols_in_use <= cfg_data[8:0];
        hcsc_pkg::REG_ROWS:      rows_in_use <= cfg_data[8:0];
        hcsc_pkg::REG_FOCUS_LOW: focus_low   <= cfg_data;
        hcsc_pkg::REG_FOCUS_HI:  focus_high  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Item sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      m_tvalid  <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      // A result taken by the receiver is dropped unless a new one is loaded.
      if (m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            hit_q     <= in_hit;
            img_col_q <= rx[7:0];
            img_row_q <= row_img[7:0];
            val_q     <= s_tdata[47:32];
            if (!in_hit) begin
              state <= S_DONE;
            end else if (s_tuser) begin
              state <= S_MEM;
            end else begin
              state <= S_CLASS;
            end
          end
        end
        S_MEM: begin
          val_q <= mem_rdata;
          state <= S_CLASS;
        end
        S_CLASS: begin
          if (below) begin
            kind      <= K_BLUE_GREY;
            div_numer <= 24'({8'd0, val_q} * 24'd45);
            div_denom <= focus_low;
            div_start <= 1'b1;
            state     <= S_DIV;
          end else if (above) begin
            kind      <= K_RED_GREY;
            div_numer <= 24'({8'd0, val_q - focus_high} * 24'd45);
            div_denom <= 16'hFFFF - focus_high;
            div_start <= 1'b1;
            state     <= S_DIV;
          end else if (flat) begin
            red_q   <= 8'd255;
            green_q <= 8'd0;
            blue_q  <= 8'd0;
            state   <= S_DONE;
          end else begin
            kind      <= K_GRAD;
            seg_q     <= seg;
            num_q     <= 17'(n4 - seg_base);
            div_denom <= span;
            chan_q    <= hcsc_pkg::CH_RED;
            state     <= S_MUL;
          end
        end
        S_MUL: begin
          div_numer <= 24'(num_q * dmag);
          div_start <= 1'b1;
          state     <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            case (kind)
              K_BLUE_GREY: begin
                red_q   <= 8'd30 + q8;
                green_q <= 8'd30 + q8;
                blue_q  <= 8'd50 + q8;
                state   <= S_DONE;
              end
              K_RED_GREY: begin
                red_q   <= 8'd115 + q8;
                green_q <= 8'd95 + q8;
                blue_q  <= 8'd95 + q8;
                state   <= S_DONE;
              end
              default: begin
                case (chan_q)
                  hcsc_pkg::CH_RED: begin
                    red_q  <= chan_val;
                    chan_q <= hcsc_pkg::CH_GREEN;
                    state  <= S_MUL;
                  end
                  hcsc_pkg::CH_GREEN: begin
                    green_q <= chan_val;
                    chan_q  <= hcsc_pkg::CH_BLUE;
                    state   <= S_MUL;
                  end
                  default: begin
                    blue_q <= chan_val;
                    state  <= S_DONE;
                  end
                endcase
              end
            endcase
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= hit_q;
            m_tdata  <= hit_q ? {blue_q, green_q, red_q, val_q, img_row_q, img_col_q}
                              : '0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "heatmap_cell_store_colormap_assert.svh"

  // Only one item is in work at a time.
  `HCSC_ASSERT(a_one_item, clk, rst, (s_tvalid && s_tready) |=> !s_tready, "second item accepted")
  // The divider reports a quotient only while the sequencer waits for it.
  `HCSC_NEVER(a_div_state, clk, rst, div_done && (state != S_DIV), "stray divider result")
  // A result waiting on the output is never overwritten.
  `HCSC_ASSERT(a_out_hold, clk, rst, (m_tvalid && !m_tready) |=> $stable(m_tdata), "result overwritten")

endmodule
